/* hw/rtl/ept_pkg.sv */
// echo probe tracker package: item types, control structs, protocol constants
// and the probe checksum function; no dependencies
`timescale 1ns / 1ps

package ept_pkg;

  localparam int REQUEST_SLOTS = 8;
  localparam int DELAY_ENTRIES = 16;
  localparam int TIME_WIDTH    = 48;

  localparam int SLOT_IDX_W   = (REQUEST_SLOTS > 1) ? $clog2(REQUEST_SLOTS) : 1;
  localparam int DLY_IDX_W    = (DELAY_ENTRIES > 1) ? $clog2(DELAY_ENTRIES) : 1;
  localparam int DELAY_SLOT_W = 4;

  localparam logic [15:0] ECHO_TYPE_CODE = 16'h0800;
  localparam logic [7:0]  ECHO_IDENT     = 8'h13;
  localparam logic [31:0] ECHO_PAYLOAD   = 32'h3472_0803;
  localparam logic [7:0]  REPLY_TYPE     = 8'h00;

  typedef enum logic [1:0] {
    OUT_SENT    = 2'd0,
    OUT_MATCH   = 2'd1,
    OUT_INVALID = 2'd2,
    OUT_STRAY   = 2'd3
  } outcome_t;

  typedef struct packed {
    logic                  mode;
    logic [TIME_WIDTH-1:0] now;
    logic [15:0]           reply_seq;
    logic [7:0]            reply_type;
    logic [15:0]           reply_id;
    logic [31:0]           reply_payload;
    logic                  reply_length_ok;
  } ept_in_t;

  typedef struct packed {
    outcome_t              outcome;
    logic [15:0]           probe_seq;
    logic [15:0]           probe_checksum;
    logic [TIME_WIDTH-1:0] round_trip;
    logic [3:0]            delay_slot;
  } ept_out_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic ring_wr;
    logic result_ld;
  } ept_cmd_t;

  typedef struct packed {
    logic is_send;
    logic reply_ok;
    logic hit;
  } ept_sts_t;

  // ones-complement sum of the five request words, folded and inverted
  function automatic logic [15:0] probe_sum(input logic [15:0] seq);
    logic [17:0] s;
    logic [16:0] f;
    s = 18'(ECHO_TYPE_CODE) + 18'({ECHO_IDENT, 8'h00}) + 18'(seq)
      + 18'(ECHO_PAYLOAD[31:16]) + 18'(ECHO_PAYLOAD[15:0]);
    f = 17'(s[17:16]) + 17'(s[15:0]);
    f = f + 17'(f[16]);
    return ~f[15:0];
  endfunction

endpackage

/* hw/rtl/ept_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ept_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/ept_ctrl.sv */
// echo probe tracker controller: sequences one item through the datapath
// and owns the result valid flag; depends on ept_pkg
`timescale 1ns / 1ps

module ept_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  ept_pkg::ept_sts_t sts,
  output ept_pkg::ept_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIFF,
    ST_READ,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (!sts.is_send && sts.reply_ok && sts.hit) begin
          state_nxt = ST_DIFF;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIFF: begin
        cmd.ring_wr = 1'b1;
        state_nxt   = ST_READ;
      end
      // ring entry written last cycle is read back here
      ST_READ: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.result_ld = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/ept_datapath.sv */
// echo probe tracker datapath: request slots, reply checks, slot search,
// delay ring and result register; depends on ept_pkg and ept_ram
`timescale 1ns / 1ps

module ept_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  ept_pkg::ept_in_t  in_item,
  input  ept_pkg::ept_cmd_t cmd,
  output ept_pkg::ept_sts_t sts,
  output ept_pkg::ept_out_t out_item
);

  ept_pkg::ept_in_t item_r;

  logic                           slot_vld_r  [ept_pkg::REQUEST_SLOTS];
  logic [15:0]                    slot_seq_r  [ept_pkg::REQUEST_SLOTS];
  logic [ept_pkg::TIME_WIDTH-1:0] slot_time_r [ept_pkg::REQUEST_SLOTS];
  logic [ept_pkg::SLOT_IDX_W-1:0] slot_ptr_r;
  logic [15:0]                    next_seq_r;
  logic [ept_pkg::DLY_IDX_W-1:0]  dly_ptr_r;
  logic [ept_pkg::DLY_IDX_W-1:0]  dly_last_r;
  logic [ept_pkg::SLOT_IDX_W-1:0] match_idx_r;
  ept_pkg::outcome_t              res_outcome_r;
  logic [15:0]                    res_seq_r;
  logic [15:0]                    res_chk_r;
  ept_pkg::ept_out_t              out_r;

  logic                           reply_ok;
  logic                           hit;
  logic [ept_pkg::SLOT_IDX_W-1:0] hit_idx;
  logic [ept_pkg::TIME_WIDTH-1:0] delay;
  logic [ept_pkg::TIME_WIDTH-1:0] ring_rd;

  assign reply_ok = item_r.reply_length_ok
                 && (item_r.reply_type == ept_pkg::REPLY_TYPE)
                 && (item_r.reply_id == 16'(ept_pkg::ECHO_IDENT))
                 && (item_r.reply_payload == ept_pkg::ECHO_PAYLOAD);

  // lowest valid slot with the same sequence number wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = ept_pkg::REQUEST_SLOTS - 1; i >= 0; i--) begin
      if (slot_vld_r[i] && (slot_seq_r[i] == item_r.reply_seq)) begin
        hit     = 1'b1;
        hit_idx = ept_pkg::SLOT_IDX_W'(i);
      end
    end
  end

  assign sts.is_send  = ~item_r.mode;
  assign sts.reply_ok = reply_ok;
  assign sts.hit      = hit;

  // difference wraps at the time width
  assign delay = item_r.now - slot_time_r[match_idx_r];

  ept_ram #(
    .WIDTH (ept_pkg::TIME_WIDTH),
    .DEPTH (ept_pkg::DELAY_ENTRIES)
  ) u_delay_ring (
    .clk     (clk),
    .wr_en   (cmd.ring_wr),
    .wr_addr (dly_ptr_r),
    .wr_data (delay),
    .rd_addr (dly_last_r),
    .rd_data (ring_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ept_pkg::REQUEST_SLOTS; i++) begin
        slot_vld_r[i] <= 1'b0;
      end
      slot_ptr_r <= '0;
      next_seq_r <= '0;
      dly_ptr_r  <= '0;
    end else begin
      if (cmd.eval && !item_r.mode) begin
        slot_vld_r[slot_ptr_r] <= 1'b1;
        slot_ptr_r <= (slot_ptr_r == ept_pkg::SLOT_IDX_W'(ept_pkg::REQUEST_SLOTS - 1))
                      ? '0 : slot_ptr_r + 1'b1;
        next_seq_r <= next_seq_r + 16'd1;
      end
      if (cmd.ring_wr) begin
        dly_ptr_r <= (dly_ptr_r == ept_pkg::DLY_IDX_W'(ept_pkg::DELAY_ENTRIES - 1))
                     ? '0 : dly_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.eval) begin
      if (!item_r.mode) begin
        slot_seq_r[slot_ptr_r]  <= next_seq_r;
        slot_time_r[slot_ptr_r] <= item_r.now;
        res_outcome_r           <= ept_pkg::OUT_SENT;
        res_seq_r               <= next_seq_r;
        res_chk_r               <= ept_pkg::probe_sum(next_seq_r);
      end else begin
        res_seq_r <= '0;
        res_chk_r <= '0;
        if (!reply_ok) begin
          res_outcome_r <= ept_pkg::OUT_INVALID;
        end else if (hit) begin
          res_outcome_r <= ept_pkg::OUT_MATCH;
        end else begin
          res_outcome_r <= ept_pkg::OUT_STRAY;
        end
      end
      match_idx_r <= hit_idx;
    end
    if (cmd.ring_wr) begin
      dly_last_r <= dly_ptr_r;
    end
    if (cmd.result_ld) begin
      out_r.outcome        <= res_outcome_r;
      out_r.probe_seq      <= res_seq_r;
      out_r.probe_checksum <= res_chk_r;
      if (res_outcome_r == ept_pkg::OUT_MATCH) begin
        out_r.round_trip <= ring_rd;
        out_r.delay_slot <= ept_pkg::DELAY_SLOT_W'(dly_last_r);
      end else begin
        out_r.round_trip <= '0;
        out_r.delay_slot <= '0;
      end
    end
  end

  assign out_item = out_r;

endmodule

/* hw/rtl/echo_probe_rtt_tracker.sv */
// echo probe round-trip tracker, top level: controller plus datapath
// depends on ept_pkg, ept_ctrl, ept_datapath
//
//   channel | ports                           | payload
//   input   | in_valid, in_stall, in_item     | ept_pkg::ept_in_t
//   result  | out_valid, out_stall, out_item  | ept_pkg::ept_out_t
//
// one item at a time: a send or a rejected reply goes from accept to result
// through search alone, a matched reply through search, ring write, ring read-back.
// the slot search compares all request slots in parallel.
// the result sits in an output register; a stalled result holds the
// controller in its final state until taken. synchronous active-low reset
// clears slot valid bits, pointers and the sequence counter.
`timescale 1ns / 1ps

module echo_probe_rtt_tracker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ept_pkg::ept_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output ept_pkg::ept_out_t out_item
);

  ept_pkg::ept_cmd_t cmd;
  ept_pkg::ept_sts_t sts;

  ept_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ept_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

/* hw/rtl/ept_checker.sv */
// port-level checks for the echo probe tracker, bound to the top level
// depends on ept_pkg
`timescale 1ns / 1ps

module ept_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input ept_pkg::ept_in_t  in_item,
  input logic              out_valid,
  input logic              out_stall,
  input ept_pkg::ept_out_t out_item
);

  // one item in flight: an accepted item blocks the next one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted back to back");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_reply_no_probe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.outcome != ept_pkg::OUT_SENT)
      |-> (out_item.probe_seq == 16'd0) && (out_item.probe_checksum == 16'd0))
    else $error("reply result carries probe fields");

  a_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.outcome != ept_pkg::OUT_MATCH)
      |-> (out_item.round_trip == '0) && (out_item.delay_slot == 4'd0))
    else $error("unmatched result carries a delay");

endmodule

bind echo_probe_rtt_tracker ept_checker u_ept_checker (.*);

/* verif/tb_echo_probe_rtt_tracker.sv */
// testbench for echo_probe_rtt_tracker: directed and random probe/reply items
// checked against an in-bench predictor of sequence, checksum and round trip
// depends on ept_pkg and the echo_probe_rtt_tracker rtl
`timescale 1ns / 1ps

module tb_echo_probe_rtt_tracker;
  import ept_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1400;

  class rtt_scoreboard;
    logic [15:0]           seq_ctr;
    logic                  slot_live  [REQUEST_SLOTS];
    logic [15:0]           slot_seq   [REQUEST_SLOTS];
    logic [TIME_WIDTH-1:0] slot_stamp [REQUEST_SLOTS];
    int unsigned           req_ptr;
    int unsigned           dly_ptr;
    ept_out_t              pending[$];
    int                    errors;

    function void clear_state();
      seq_ctr = '0;
      req_ptr = 0;
      dly_ptr = 0;
      errors  = 0;
      pending.delete();
      for (int i = 0; i < REQUEST_SLOTS; i++) begin
        slot_live[i]  = 1'b0;
        slot_seq[i]   = '0;
        slot_stamp[i] = '0;
      end
    endfunction

    // ones-complement sum over the five request words, folded twice
    function logic [15:0] echo_checksum(logic [15:0] seq);
      logic [31:0] acc;
      acc = 32'(ECHO_TYPE_CODE) + 32'({ECHO_IDENT, 8'h00}) + 32'(seq)
          + 32'(ECHO_PAYLOAD[31:16]) + 32'(ECHO_PAYLOAD[15:0]);
      acc = (acc >> 16) + (acc & 32'hffff);
      acc = acc + (acc >> 16);
      return ~acc[15:0];
    endfunction

    function void note_item(ept_in_t it);
      ept_out_t e;
      int       hit;
      e = '0;
      hit = -1;
      if (!it.mode) begin
        e.outcome        = OUT_SENT;
        e.probe_seq      = seq_ctr;
        e.probe_checksum = echo_checksum(seq_ctr);
        slot_live[req_ptr]  = 1'b1;
        slot_seq[req_ptr]   = seq_ctr;
        slot_stamp[req_ptr] = it.now;
        req_ptr = (req_ptr + 1) % REQUEST_SLOTS;
        seq_ctr = seq_ctr + 16'd1;
      end else if (!it.reply_length_ok || it.reply_type != REPLY_TYPE ||
                   it.reply_id != 16'(ECHO_IDENT) || it.reply_payload != ECHO_PAYLOAD) begin
        e.outcome = OUT_INVALID;
      end else begin
        for (int i = 0; i < REQUEST_SLOTS; i++)
          if (hit < 0 && slot_live[i] && slot_seq[i] == it.reply_seq) hit = i;
        if (hit < 0) begin
          e.outcome = OUT_STRAY;
        end else begin
          // slot stays live, so a repeated reply matches again
          e.outcome    = OUT_MATCH;
          e.round_trip = it.now - slot_stamp[hit];
          e.delay_slot = 4'(dly_ptr);
          dly_ptr = (dly_ptr + 1) % DELAY_ENTRIES;
        end
      end
      pending.push_back(e);
    endfunction

    function string show(ept_out_t r);
      return $sformatf("outcome %0d seq %h csum %h rtt %h slot %0d",
                       r.outcome, r.probe_seq, r.probe_checksum, r.round_trip, r.delay_slot);
    endfunction

    function void check_result(ept_out_t got);
      ept_out_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %s", show(got));
      end else begin
        e = pending.pop_front();
        if (got.outcome !== e.outcome || got.probe_seq !== e.probe_seq ||
            got.probe_checksum !== e.probe_checksum || got.round_trip !== e.round_trip ||
            got.delay_slot !== e.delay_slot) begin
          errors++;
          if (errors <= 10) $display("result mismatch\n  expected %s\n  actual   %s",
                                     show(e), show(got));
        end
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  ept_in_t  in_item;
  logic     out_valid;
  logic     out_stall;
  ept_out_t out_item;

  rtt_scoreboard sb = new;

  logic [TIME_WIDTH-1:0] t_now;
  logic [15:0]           recent[$];
  bit                    quiet_in;
  int                    idle_cycles;

  echo_probe_rtt_tracker i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_item(in_item);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure, with calm stretches in between
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : pick_gap();
      repeat (n + 1) @(negedge clk) out_stall <= 1'b0;
      n = pick_gap();
      repeat (n) @(negedge clk) out_stall <= 1'b1;
    end
  end

  task automatic drive_item(ept_in_t it);
    int gap;
    gap = quiet_in ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic ept_in_t probe_item(logic [TIME_WIDTH-1:0] t);
    ept_in_t it;
    it = '0;
    it.mode = 1'b0;
    it.now  = t;
    it.reply_seq = 16'($urandom);
    return it;
  endfunction

  function automatic ept_in_t reply_item(logic [15:0] seq, logic [TIME_WIDTH-1:0] t);
    ept_in_t it;
    it.mode            = 1'b1;
    it.now             = t;
    it.reply_seq       = seq;
    it.reply_type      = REPLY_TYPE;
    it.reply_id        = 16'(ECHO_IDENT);
    it.reply_payload   = ECHO_PAYLOAD;
    it.reply_length_ok = 1'b1;
    return it;
  endfunction

  function automatic logic [TIME_WIDTH-1:0] rand_time();
    return TIME_WIDTH'({$urandom, $urandom});
  endfunction

  task automatic send_probe(logic [TIME_WIDTH-1:0] t);
    recent.push_back(sb.seq_ctr);
    if (recent.size() > 12) void'(recent.pop_front());
    drive_item(probe_item(t));
  endtask

  task automatic run_random();
    ept_in_t it;
    int      kind;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 250 == 0) quiet_in = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 29) == 0) t_now = rand_time();
      else t_now = t_now + TIME_WIDTH'($urandom_range(0, 5000));
      kind = $urandom_range(0, 99);
      if (kind < 38 || recent.size() == 0) begin
        send_probe(t_now);
      end else if (kind < 78) begin
        // mostly live sequences, the oldest ones already overwritten
        drive_item(reply_item(recent[$urandom_range(0, recent.size() - 1)], t_now));
      end else if (kind < 86) begin
        drive_item(reply_item(16'($urandom), t_now));
      end else if (kind < 95) begin
        it = reply_item(recent[$urandom_range(0, recent.size() - 1)], t_now);
        case ($urandom_range(0, 3))
          0: it.reply_length_ok = 1'b0;
          1: it.reply_type = 8'($urandom_range(1, 255));
          2: it.reply_id = it.reply_id ^ 16'($urandom_range(1, 65535));
          default: it.reply_payload = it.reply_payload ^ (32'h1 << $urandom_range(0, 31));
        endcase
        drive_item(it);
      end else begin
        it.mode            = 1'($urandom);
        it.now             = rand_time();
        it.reply_seq       = 16'($urandom);
        it.reply_type      = 8'($urandom);
        it.reply_id        = 16'($urandom);
        it.reply_payload   = $urandom;
        it.reply_length_ok = 1'($urandom);
        drive_item(it);
      end
    end
  endtask

  initial begin
    ept_in_t it;
    logic [TIME_WIDTH-1:0] t_max;
    t_max    = '1;
    quiet_in = 1'b0;
    t_now    = '0;
    sb.clear_state();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reply before any probe: slots are all clear
    drive_item(reply_item(16'h0000, '0));
    send_probe('0);
    drive_item(reply_item(16'h0000, 48'd100));
    drive_item(reply_item(16'h0000, 48'd250));
    send_probe(t_max);
    // time wraps past the top
    drive_item(reply_item(16'h0001, 48'd5));
    drive_item(reply_item(16'h0001, t_max));
    it = reply_item(16'h0000, 48'd7);
    it.reply_length_ok = 1'b0;
    drive_item(it);
    it = reply_item(16'h0000, 48'd7);
    it.reply_type = 8'h08;
    drive_item(it);
    it.reply_type = 8'hff;
    drive_item(it);
    it = reply_item(16'h0000, 48'd7);
    it.reply_id = {ECHO_IDENT, 8'h00};
    drive_item(it);
    it.reply_id = 16'hffff;
    drive_item(it);
    it = reply_item(16'h0000, 48'd7);
    it.reply_payload = 32'h0308_7234;
    drive_item(it);
    it.reply_payload = 32'hffff_ffff;
    drive_item(it);
    drive_item(reply_item(16'hffff, 48'd9));
    // fill the ring so slot 0 is overwritten
    for (int i = 0; i < REQUEST_SLOTS; i++) send_probe(48'd1000 + 48'(i));
    drive_item(reply_item(16'h0000, 48'd2000));
    drive_item(reply_item(16'(REQUEST_SLOTS), 48'd2000));

    // probes and replies with no input gaps
    quiet_in = 1'b1;
    for (int i = 0; i < 4; i++) send_probe(t_now + 48'(i));
    drive_item(reply_item(sb.seq_ctr - 16'd1, t_now + 48'd50));
    drive_item(reply_item(sb.seq_ctr - 16'd4, t_now + 48'd60));
    quiet_in = 1'b0;

    run_random();

    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
